// ===== rtl/motor_feedback_multiturn_tracker_defines.svh =====
// Assertion macros used by the motor feedback tracker top level.
`ifndef MOTOR_FEEDBACK_MULTITURN_TRACKER_DEFINES_SVH
`define MOTOR_FEEDBACK_MULTITURN_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MFT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/mft_pkg.sv =====
// Types and constants of the motor feedback multi-turn tracker.
package mft_pkg;

  localparam int unsigned IDENT_W = 11;
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned TURN_W  = 32;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned FULL_TURN_SHIFT = 13;

  localparam logic signed [ANGLE_W:0] HALF_TURN     = 17'sd4096;
  localparam logic signed [ANGLE_W:0] NEG_HALF_TURN = -17'sd4096;

  localparam logic [IDENT_W-1:0] BASE_IDENTIFIER_RESET    = 11'd513;
  localparam logic [COUNT_W-1:0] CALIBRATION_FRAMES_RESET = 8'd50;
  localparam logic [COUNT_W-1:0] FRAME_COUNT_MAX          = 8'hFF;

  // Configuration register indexes.
  localparam logic CFG_BASE_IDENTIFIER    = 1'b0;
  localparam logic CFG_CALIBRATION_FRAMES = 1'b1;

  localparam logic BUS_FIRST = 1'b0;

  typedef struct packed {
    logic [IDENT_W-1:0] base_identifier;
    logic [COUNT_W-1:0] calibration_frames;
  } cfg_t;

  typedef struct packed {
    logic                      bus_select;
    logic [IDENT_W-1:0]        frame_identifier;
    logic [ANGLE_W-1:0]        angle_word;
    logic signed [15:0]        speed_word;
    logic signed [15:0]        current_word;
    logic [7:0]                temperature_byte;
  } item_t;

  typedef struct packed {
    logic                      matched;
    logic [1:0]                motor_index;
    logic                      calibrating;
    logic [ANGLE_W-1:0]        angle_now;
    logic signed [15:0]        speed_now;
    logic signed [15:0]        current_now;
    logic [7:0]                temperature_now;
    logic signed [TURN_W-1:0]  turn_count;
    logic signed [TURN_W-1:0]  multiturn_angle;
  } result_t;

endpackage

// ===== rtl/mft_ifs.sv =====
// Valid/ready channel interfaces for feedback frames and tracker results.
interface mft_frame_if;
  logic               valid;
  logic               ready;
  logic               bus_select;
  logic [10:0]        frame_identifier;
  logic [15:0]        angle_word;
  logic signed [15:0] speed_word;
  logic signed [15:0] current_word;
  logic [7:0]         temperature_byte;

  modport source (output valid, bus_select, frame_identifier, angle_word, speed_word,
                  current_word, temperature_byte, input ready);
  modport sink   (input valid, bus_select, frame_identifier, angle_word, speed_word,
                  current_word, temperature_byte, output ready);
endinterface

interface mft_result_if;
  logic               valid;
  logic               ready;
  logic               matched;
  logic [1:0]         motor_index;
  logic               calibrating;
  logic [15:0]        angle_now;
  logic signed [15:0] speed_now;
  logic signed [15:0] current_now;
  logic [7:0]         temperature_now;
  logic signed [31:0] turn_count;
  logic signed [31:0] multiturn_angle;

  modport source (output valid, matched, motor_index, calibrating, angle_now, speed_now,
                  current_now, temperature_now, turn_count, multiturn_angle, input ready);
  modport sink   (input valid, matched, motor_index, calibrating, angle_now, speed_now,
                  current_now, temperature_now, turn_count, multiturn_angle, output ready);
endinterface

// ===== rtl/mft_in_stage.sv =====
// Input register stage that holds one accepted feedback word.
module mft_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mft_pkg::item_t in_item_i,
  input  logic          adv_i,
  output logic          valid_o,
  output mft_pkg::item_t item_o
);

  logic           valid_q, valid_d;
  mft_pkg::item_t item_q;
  logic           accept;

  assign in_ready_o = !valid_q || adv_i;
  assign accept     = in_valid_i && in_ready_o;
  assign valid_d    = (valid_q && !adv_i) || accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/mft_track_core.sv =====
// Motor selection, per-motor state and the turn/total angle update.
module mft_track_core #(
  parameter int unsigned MOTOR_COUNT = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mft_pkg::cfg_t    cfg_i,
  input  mft_pkg::item_t   item_i,
  input  logic             commit_i,
  output mft_pkg::result_t res_o
);

  localparam int unsigned IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

  logic [mft_pkg::ANGLE_W-1:0] prev_angle_q [MOTOR_COUNT];
  logic [mft_pkg::ANGLE_W-1:0] offset_q     [MOTOR_COUNT];
  logic [mft_pkg::TURN_W-1:0]  turn_q       [MOTOR_COUNT];
  logic [mft_pkg::COUNT_W-1:0] count_q      [MOTOR_COUNT];

  logic [mft_pkg::IDENT_W:0]   id_off;
  logic [IDX_W-1:0]            idx;
  logic                        matched;
  logic                        calib;
  logic [mft_pkg::ANGLE_W-1:0] angle;
  logic [mft_pkg::ANGLE_W-1:0] prev_angle;
  logic [mft_pkg::ANGLE_W-1:0] offset_d;
  logic [mft_pkg::TURN_W-1:0]  turn_old;
  logic [mft_pkg::TURN_W-1:0]  turn_d;
  logic [mft_pkg::COUNT_W-1:0] count_old;
  logic [mft_pkg::COUNT_W-1:0] count_d;
  logic signed [mft_pkg::ANGLE_W:0] jump;
  logic signed [mft_pkg::ANGLE_W:0] rel_angle;
  logic [mft_pkg::TURN_W-1:0]  total;
  logic                        wr_en;

  // The identifier offset carries a borrow bit so that ids below the base never match.
  assign id_off  = {1'b0, item_i.frame_identifier} - {1'b0, cfg_i.base_identifier};
  assign matched = (item_i.bus_select == mft_pkg::BUS_FIRST) && !id_off[mft_pkg::IDENT_W] &&
                   (id_off[mft_pkg::IDENT_W-1:0] < mft_pkg::IDENT_W'(MOTOR_COUNT));
  assign idx     = id_off[IDX_W-1:0];
  assign angle   = item_i.angle_word;

  assign prev_angle = prev_angle_q[idx];
  assign turn_old   = turn_q[idx];
  assign count_old  = count_q[idx];

  assign calib   = count_old <= cfg_i.calibration_frames;
  assign count_d = (count_old == mft_pkg::FRAME_COUNT_MAX) ? count_old
                                                           : count_old + 1'b1;
  assign offset_d = calib ? angle : offset_q[idx];

  assign jump = $signed({1'b0, angle}) - $signed({1'b0, prev_angle});

  always_comb begin
    turn_d = turn_old;
    if (!calib) begin
      if (jump > mft_pkg::HALF_TURN) begin
        turn_d = turn_old - 1'b1;
      end else if (jump < mft_pkg::NEG_HALF_TURN) begin
        turn_d = turn_old + 1'b1;
      end
    end
  end

  assign rel_angle = $signed({1'b0, angle}) - $signed({1'b0, offset_d});
  assign total     = {turn_d[mft_pkg::TURN_W-mft_pkg::FULL_TURN_SHIFT-1:0],
                      {mft_pkg::FULL_TURN_SHIFT{1'b0}}} +
                     mft_pkg::TURN_W'(rel_angle);

  assign wr_en = commit_i && matched;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MOTOR_COUNT; k++) begin
        prev_angle_q[k] <= '0;
        offset_q[k]     <= '0;
        turn_q[k]       <= '0;
        count_q[k]      <= '0;
      end
    end else if (wr_en) begin
      prev_angle_q[idx] <= angle;
      offset_q[idx]     <= offset_d;
      turn_q[idx]       <= turn_d;
      count_q[idx]      <= count_d;
    end
  end

  always_comb begin
    res_o = '0;
    if (matched) begin
      res_o.matched         = 1'b1;
      res_o.motor_index     = id_off[1:0];
      res_o.calibrating     = calib;
      res_o.angle_now       = angle;
      res_o.turn_count      = turn_d;
      res_o.multiturn_angle = total;
      if (!calib) begin
        res_o.speed_now       = item_i.speed_word;
        res_o.current_now     = item_i.current_word;
        res_o.temperature_now = item_i.temperature_byte;
      end
    end
  end

endmodule

// ===== rtl/motor_feedback_multiturn_tracker.sv =====
// Top level of the motor feedback multi-turn angle tracker.
// Usage:
// frame_i takes one received feedback word per handshake: bus, identifier, angle,
// speed, current and temperature. result_o gives exactly one word per frame, in
// order: matched, motor index, calibration flag, passthrough values, the signed
// turn count and the total angle. Words from the second bus or outside the four
// identifiers from base_identifier give an all-zero result and change nothing.
// A frame accepted into the input register moves through the per-motor
// read-modify-write into the result register whenever that register is empty or
// being drained. Throughput is one frame per cycle while the receiver is ready;
// the per-motor state is updated in the same cycle it is read, so consecutive
// frames to one motor need no stall.
// When the receiver stalls, the result register holds and the input register
// still takes one more frame; after that frame_i.ready drops until a result leaves.
// Reset clears all per-motor state and loads base_identifier 513 and
// calibration_frames 50. Configuration is written through cfg_we_i, cfg_idx_i and
// cfg_data_i, by the user only while no frame is in flight; the block does not check.
`include "motor_feedback_multiturn_tracker_defines.svh"

module motor_feedback_multiturn_tracker #(
  parameter int unsigned MOTOR_COUNT = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [mft_pkg::CFG_W-1:0]    cfg_data_i,
  mft_frame_if.sink                    frame_i,
  mft_result_if.source                 result_o
);

  mft_pkg::cfg_t    cfg_q;
  mft_pkg::item_t   in_item;
  mft_pkg::item_t   s1_item;
  mft_pkg::result_t res;
  mft_pkg::result_t res_q;
  logic             s1_valid;
  logic             adv;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_identifier    <= mft_pkg::BASE_IDENTIFIER_RESET;
      cfg_q.calibration_frames <= mft_pkg::CALIBRATION_FRAMES_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mft_pkg::CFG_BASE_IDENTIFIER: begin
          cfg_q.base_identifier <= cfg_data_i[mft_pkg::IDENT_W-1:0];
        end
        mft_pkg::CFG_CALIBRATION_FRAMES: begin
          cfg_q.calibration_frames <= cfg_data_i[mft_pkg::COUNT_W-1:0];
        end
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  assign in_item.bus_select       = frame_i.bus_select;
  assign in_item.frame_identifier = frame_i.frame_identifier;
  assign in_item.angle_word       = frame_i.angle_word;
  assign in_item.speed_word       = frame_i.speed_word;
  assign in_item.current_word     = frame_i.current_word;
  assign in_item.temperature_byte = frame_i.temperature_byte;

  mft_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (frame_i.valid),
    .in_ready_o (frame_i.ready),
    .in_item_i  (in_item),
    .adv_i      (adv),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  // The held frame moves on whenever the result register is empty or being drained.
  assign adv = s1_valid && (!out_valid_q || result_o.ready);

  mft_track_core #(
    .MOTOR_COUNT (MOTOR_COUNT)
  ) u_track_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .item_i   (s1_item),
    .commit_i (adv),
    .res_o    (res)
  );

  assign out_valid_d = adv || (out_valid_q && !result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.matched         = res_q.matched;
  assign result_o.motor_index     = res_q.motor_index;
  assign result_o.calibrating     = res_q.calibrating;
  assign result_o.angle_now       = res_q.angle_now;
  assign result_o.speed_now       = res_q.speed_now;
  assign result_o.current_now     = res_q.current_now;
  assign result_o.temperature_now = res_q.temperature_now;
  assign result_o.turn_count      = res_q.turn_count;
  assign result_o.multiturn_angle = res_q.multiturn_angle;

  `MFT_ASSERT_NOW(a_unmatched_zero, clk_i, rst_ni,
    out_valid_q && !res_q.matched,
    res_q.turn_count == '0 && res_q.multiturn_angle == '0 && !res_q.calibrating)
  `MFT_ASSERT_NOW(a_calib_no_passthrough, clk_i, rst_ni,
    out_valid_q && res_q.calibrating,
    res_q.matched && res_q.speed_now == '0 && res_q.current_now == '0)
  `MFT_ASSERT_NOW(a_full_blocks_input, clk_i, rst_ni,
    s1_valid && out_valid_q && !result_o.ready, !frame_i.ready)
  `MFT_ASSERT_NEXT(a_drain_refills, clk_i, rst_ni,
    s1_valid && out_valid_q && result_o.ready, out_valid_q)

endmodule

// ===== verif/motor_feedback_multiturn_tracker_tb.sv =====
// Self-checking testbench for the motor feedback multi-turn angle tracker.
module motor_feedback_multiturn_tracker_tb;

  localparam int unsigned MOTORS       = 4;
  localparam int unsigned ITEMS_PHASE  = 610;
  localparam int unsigned LONG_HOLD    = 100;
  localparam int unsigned WATCHDOG_MAX = 2000;
  localparam int unsigned DIR_ROWS     = 26;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_IGNORED,
    ROW_FIRST_CAL,
    ROW_CONFIG
  } row_kind_e;

  typedef struct {
    row_kind_e                   kind;
    logic                        cfg_idx;
    logic [mft_pkg::CFG_W-1:0]   value;
    logic                        bus;
    logic [mft_pkg::IDENT_W-1:0] ident;
    logic [15:0]                 angle;
    logic [15:0]                 speed;
    logic [15:0]                 current;
    logic [7:0]                  temp;
    logic [1:0]                  motor;
  } dir_row_t;

  logic                      clk;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic                      cfg_idx_i;
  logic [mft_pkg::CFG_W-1:0] cfg_data_i;

  mft_frame_if  frame_if ();
  mft_result_if result_if ();

  motor_feedback_multiturn_tracker uut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .frame_i    (frame_if),
    .result_o   (result_if)
  );

  // Tracker model state and its copy of the configuration.
  logic [mft_pkg::IDENT_W-1:0] tr_base;
  logic [mft_pkg::COUNT_W-1:0] tr_cal_frames;
  logic [mft_pkg::ANGLE_W-1:0] tr_prev_angle [MOTORS] = '{default: '0};
  logic [mft_pkg::ANGLE_W-1:0] tr_offset     [MOTORS] = '{default: '0};
  logic [mft_pkg::TURN_W-1:0]  tr_turns      [MOTORS] = '{default: '0};
  logic [mft_pkg::COUNT_W-1:0] tr_frames     [MOTORS] = '{default: '0};

  mft_pkg::result_t pending_results[$];
  int unsigned      mismatch_count = 0;
  int unsigned      tx_idle_pct;
  int unsigned      rx_idle_pct;
  int unsigned      hold_requests = 0;
  bit               use_typed;
  mft_pkg::result_t typed_word;
  int unsigned      quiet_cycles = 0;
  dir_row_t         dir_rows [DIR_ROWS];

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic mft_pkg::result_t track_frame(input mft_pkg::item_t f);
    mft_pkg::result_t            r;
    logic [mft_pkg::IDENT_W-1:0] slot;
    logic                        calib;
    logic signed [16:0]          jump;
    r = '0;
    if (f.bus_select != mft_pkg::BUS_FIRST || f.frame_identifier < tr_base) return r;
    slot = f.frame_identifier - tr_base;
    if (slot >= MOTORS) return r;
    calib = tr_frames[slot] <= tr_cal_frames;
    if (tr_frames[slot] != mft_pkg::FRAME_COUNT_MAX) tr_frames[slot] = tr_frames[slot] + 1'b1;
    if (calib) begin
      tr_prev_angle[slot] = f.angle_word;
      tr_offset[slot]     = f.angle_word;
    end else begin
      jump = $signed({1'b0, f.angle_word}) - $signed({1'b0, tr_prev_angle[slot]});
      tr_prev_angle[slot] = f.angle_word;
      if (jump > mft_pkg::HALF_TURN) tr_turns[slot] = tr_turns[slot] - 1'b1;
      else if (jump < mft_pkg::NEG_HALF_TURN) tr_turns[slot] = tr_turns[slot] + 1'b1;
      r.speed_now       = f.speed_word;
      r.current_now     = f.current_word;
      r.temperature_now = f.temperature_byte;
    end
    r.matched         = 1'b1;
    r.motor_index     = slot[1:0];
    r.calibrating     = calib;
    r.angle_now       = f.angle_word;
    r.turn_count      = tr_turns[slot];
    r.multiturn_angle = (tr_turns[slot] << mft_pkg::FULL_TURN_SHIFT) + {16'd0, f.angle_word}
                        - {16'd0, tr_offset[slot]};
    return r;
  endfunction

  task automatic note_mismatch(input string field, input longint want, input longint got);
    mismatch_count++;
    $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, field, want, got);
  endtask

  task automatic check_result(input mft_pkg::result_t want, input mft_pkg::result_t got);
    if (got.matched !== want.matched) note_mismatch("matched", want.matched, got.matched);
    if (got.motor_index !== want.motor_index)
      note_mismatch("motor_index", want.motor_index, got.motor_index);
    if (got.calibrating !== want.calibrating)
      note_mismatch("calibrating", want.calibrating, got.calibrating);
    if (got.angle_now !== want.angle_now)
      note_mismatch("angle_now", want.angle_now, got.angle_now);
    if (got.speed_now !== want.speed_now)
      note_mismatch("speed_now", want.speed_now, got.speed_now);
    if (got.current_now !== want.current_now)
      note_mismatch("current_now", want.current_now, got.current_now);
    if (got.temperature_now !== want.temperature_now)
      note_mismatch("temperature_now", want.temperature_now, got.temperature_now);
    if (got.turn_count !== want.turn_count)
      note_mismatch("turn_count", want.turn_count, got.turn_count);
    if (got.multiturn_angle !== want.multiturn_angle)
      note_mismatch("multiturn_angle", want.multiturn_angle, got.multiturn_angle);
  endtask

  always @(posedge clk) begin : monitor
    mft_pkg::item_t   seen;
    mft_pkg::result_t want;
    mft_pkg::result_t got;
    if (rst_ni) begin
      if (frame_if.valid && frame_if.ready) begin
        seen.bus_select       = frame_if.bus_select;
        seen.frame_identifier = frame_if.frame_identifier;
        seen.angle_word       = frame_if.angle_word;
        seen.speed_word       = frame_if.speed_word;
        seen.current_word     = frame_if.current_word;
        seen.temperature_byte = frame_if.temperature_byte;
        want = track_frame(seen);
        if (use_typed) want = typed_word;
        pending_results.push_back(want);
      end
      if (result_if.valid && result_if.ready) begin
        got.matched         = result_if.matched;
        got.motor_index     = result_if.motor_index;
        got.calibrating     = result_if.calibrating;
        got.angle_now       = result_if.angle_now;
        got.speed_now       = result_if.speed_now;
        got.current_now     = result_if.current_now;
        got.temperature_now = result_if.temperature_now;
        got.turn_count      = result_if.turn_count;
        got.multiturn_angle = result_if.multiturn_angle;
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: mismatch on result word, expected none, actual angle %0d",
                   $time, got.multiturn_angle);
        end else begin
          want = pending_results.pop_front();
          check_result(want, got);
        end
      end
    end
  end

  // Ends the run when neither channel has moved a word for too long.
  always @(posedge clk) begin
    if (rst_ni) begin
      if ((frame_if.valid && frame_if.ready) || (result_if.valid && result_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure, or one long hold-off for each request.
  initial begin : receiver
    int unsigned holds_served;
    holds_served = 0;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        result_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        result_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_frame(input mft_pkg::item_t f, input bit typed,
                            input mft_pkg::result_t typed_res);
    while ($urandom_range(99) < tx_idle_pct) begin
      frame_if.valid <= 1'b0;
      @(negedge clk);
    end
    frame_if.valid            <= 1'b1;
    frame_if.bus_select       <= f.bus_select;
    frame_if.frame_identifier <= f.frame_identifier;
    frame_if.angle_word       <= f.angle_word;
    frame_if.speed_word       <= f.speed_word;
    frame_if.current_word     <= f.current_word;
    frame_if.temperature_byte <= f.temperature_byte;
    use_typed  = typed;
    typed_word = typed_res;
    do @(posedge clk); while (!frame_if.ready);
    @(negedge clk);
  endtask

  // Stops offering words and waits until every expected result has left.
  task automatic drain_results();
    frame_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [mft_pkg::CFG_W-1:0] data);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == mft_pkg::CFG_BASE_IDENTIFIER) tr_base = data[mft_pkg::IDENT_W-1:0];
    else tr_cal_frames = data[mft_pkg::COUNT_W-1:0];
    @(negedge clk);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly frames addressed to the tracked motors, with angle steps up to 6000 either
  // way or near a half turn, so the turn counter moves both ways; the rest is noise.
  function automatic mft_pkg::item_t make_frame();
    mft_pkg::item_t f;
    int unsigned    pick;
    int unsigned    slot;
    int             step;
    pick = $urandom_range(99);
    f.speed_word       = 16'($urandom);
    f.current_word     = 16'($urandom);
    f.temperature_byte = 8'($urandom);
    f.angle_word       = 16'($urandom);
    if (pick < 80) begin
      slot = $urandom_range(MOTORS - 1);
      f.bus_select       = mft_pkg::BUS_FIRST;
      f.frame_identifier = tr_base + 11'(slot);
      case ($urandom_range(9)) inside
        [0:5]: step = int'($urandom_range(12000)) - 6000;
        [6:7]: begin
          case ($urandom_range(3))
            0: step = 4096;
            1: step = 4097;
            2: step = -4096;
            default: step = -4097;
          endcase
        end
        default: step = 0;
      endcase
      if (step != 0) f.angle_word = tr_prev_angle[slot] + step[15:0];
    end else if (pick < 90) begin
      f.bus_select       = ~mft_pkg::BUS_FIRST;
      f.frame_identifier = ($urandom_range(1) != 0) ? tr_base + 11'($urandom_range(3))
                                                      : 11'($urandom_range(2047));
    end else begin
      f.bus_select       = mft_pkg::BUS_FIRST;
      f.frame_identifier = 11'($urandom_range(2047));
    end
    return f;
  endfunction

  initial begin : stimulus
    mft_pkg::item_t   f;
    mft_pkg::result_t typed_res;
    dir_row_t         row;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = mft_pkg::CFG_BASE_IDENTIFIER;
    cfg_data_i    = '0;
    frame_if.valid            = 1'b0;
    frame_if.bus_select       = mft_pkg::BUS_FIRST;
    frame_if.frame_identifier = '0;
    frame_if.angle_word       = '0;
    frame_if.speed_word       = '0;
    frame_if.current_word     = '0;
    frame_if.temperature_byte = '0;
    use_typed      = 1'b0;
    typed_word     = '0;
    tx_idle_pct    = 30;
    rx_idle_pct    = 54;
    tr_base        = mft_pkg::BASE_IDENTIFIER_RESET;
    tr_cal_frames  = mft_pkg::CALIBRATION_FRAMES_RESET;

    dir_rows = '{
      // Reset configuration: the first frame of each motor calibrates.
      '{ROW_FIRST_CAL, 1'b0, 11'd0, 1'b0, 11'd513, 16'd100, 16'd7, 16'hFFF9, 8'd30, 2'd0},
      '{ROW_IGNORED, 1'b0, 11'd0, 1'b1, 11'd513, 16'd100, 16'd5, 16'd5, 8'd5, 2'd0},
      '{ROW_IGNORED, 1'b0, 11'd0, 1'b0, 11'd512, 16'd200, 16'd1, 16'd1, 8'd1, 2'd0},
      '{ROW_IGNORED, 1'b0, 11'd0, 1'b0, 11'd517, 16'd300, 16'd2, 16'd2, 8'd2, 2'd0},
      '{ROW_FIRST_CAL, 1'b0, 11'd0, 1'b0, 11'd516, 16'hFFFF, 16'h8000, 16'h7FFF, 8'hFF,
        2'd3},
      '{ROW_FIRST_CAL, 1'b0, 11'd0, 1'b0, 11'd514, 16'd0, 16'd0, 16'd0, 8'd0, 2'd1},
      '{ROW_FIRST_CAL, 1'b0, 11'd0, 1'b0, 11'd515, 16'd8191, 16'd3, 16'd4, 8'd9, 2'd2},
      '{ROW_PREDICT, 1'b0, 11'd0, 1'b0, 11'd513, 16'd120, 16'd8, 16'd9, 8'd10, 2'd0},
      // No more calibration: exactly a half turn, then just past it both ways.
      '{ROW_CONFIG, mft_pkg::CFG_CALIBRATION_FRAMES, 11'd0, 1'b0, 11'd0, 16'd0, 16'd0,
        16'd0, 8'd0, 2'd0},
      '{ROW_PREDICT, 1'b0, 11'd0, 1'b0, 11'd513, 16'd4216, 16'd11, 16'd12, 8'd13, 2'd0},
      '{ROW_PREDICT, 1'b0, 11'd0, 1'b0, 11'd513, 16'd8313, 16'd14, 16'd15, 8'd16, 2'd0},
      '{ROW_PREDICT, 1'b0, 11'd0, 1'b0, 11'd513, 16'd4216, 16'd17, 16'd18, 8'd19, 2'd0},
      '{ROW_PREDICT, 1'b0, 11'd0, 1'b0, 11'd514, 16'hFFFF, 16'h8000, 16'h7FFF, 8'hFF, 2'd1},
      '{ROW_PREDICT, 1'b0, 11'd0, 1'b0, 11'd514, 16'd0, 16'h7FFF, 16'h8000, 8'd0, 2'd1},
      '{ROW_PREDICT, 1'b0, 11'd0, 1'b0, 11'd514, 16'd0, 16'hFFFF, 16'h0001, 8'd128, 2'd1},
      // Lowest base identifier.
      '{ROW_CONFIG, mft_pkg::CFG_BASE_IDENTIFIER, 11'd0, 1'b0, 11'd0, 16'd0, 16'd0, 16'd0,
        8'd0, 2'd0},
      '{ROW_PREDICT, 1'b0, 11'd0, 1'b0, 11'd0, 16'd0, 16'd21, 16'd22, 8'd23, 2'd0},
      '{ROW_PREDICT, 1'b0, 11'd0, 1'b0, 11'd3, 16'd40000, 16'd24, 16'd25, 8'd26, 2'd3},
      '{ROW_IGNORED, 1'b0, 11'd0, 1'b0, 11'd4, 16'd50, 16'd27, 16'd28, 8'd29, 2'd0},
      '{ROW_IGNORED, 1'b0, 11'd0, 1'b1, 11'd0, 16'd60, 16'd30, 16'd31, 8'd32, 2'd0},
      // Highest base identifier with a full window, which ends at the top identifier.
      '{ROW_CONFIG, mft_pkg::CFG_BASE_IDENTIFIER, 11'd2044, 1'b0, 11'd0, 16'd0, 16'd0,
        16'd0, 8'd0, 2'd0},
      '{ROW_PREDICT, 1'b0, 11'd0, 1'b0, 11'd2047, 16'd12345, 16'd33, 16'd34, 8'd35, 2'd3},
      '{ROW_IGNORED, 1'b0, 11'd0, 1'b0, 11'd2043, 16'd70, 16'd36, 16'd37, 8'd38, 2'd0},
      '{ROW_PREDICT, 1'b0, 11'd0, 1'b0, 11'd2044, 16'd20000, 16'd39, 16'd40, 8'd41, 2'd0},
      // Wide calibration window: low frame counts calibrate again.
      '{ROW_CONFIG, mft_pkg::CFG_CALIBRATION_FRAMES, 11'd254, 1'b0, 11'd0, 16'd0, 16'd0,
        16'd0, 8'd0, 2'd0},
      '{ROW_PREDICT, 1'b0, 11'd0, 1'b0, 11'd2045, 16'd30000, 16'd42, 16'd43, 8'd44, 2'd1}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_rows[i];
      if (row.kind == ROW_CONFIG) begin
        write_register(row.cfg_idx, row.value);
      end else begin
        f.bus_select       = row.bus;
        f.frame_identifier = row.ident;
        f.angle_word       = row.angle;
        f.speed_word       = row.speed;
        f.current_word     = row.current;
        f.temperature_byte = row.temp;
        typed_res = '0;
        if (row.kind == ROW_FIRST_CAL) begin
          typed_res.matched     = 1'b1;
          typed_res.motor_index = row.motor;
          typed_res.calibrating = 1'b1;
          typed_res.angle_now   = row.angle;
        end
        send_frame(f, row.kind != ROW_PREDICT, typed_res);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          write_register(mft_pkg::CFG_BASE_IDENTIFIER, 11'($urandom_range(2044)));
          write_register(mft_pkg::CFG_CALIBRATION_FRAMES, 11'd254);
          tx_idle_pct = 30;
          rx_idle_pct = 54;
        end
        1: begin
          write_register(mft_pkg::CFG_BASE_IDENTIFIER, 11'd0);
          write_register(mft_pkg::CFG_CALIBRATION_FRAMES, 11'd0);
          tx_idle_pct = 54;
          rx_idle_pct = 30;
        end
        default: begin
          write_register(mft_pkg::CFG_BASE_IDENTIFIER, 11'd2044);
          write_register(mft_pkg::CFG_CALIBRATION_FRAMES, 11'($urandom_range(254)));
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < ITEMS_PHASE; n++) begin
        // Outside phase 1, the receiver holds off while words keep coming, so the input stalls.
        if (n == 150 && ph != 1) hold_requests++;
        if (n == 400) drain_results();
        send_frame(make_frame(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (6) @(negedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: mismatch on result count, expected %0d more words, actual 0",
               $time, pending_results.size());
    end
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
